>>> rtl/core/cpdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpdd_pkg
// Shared types, field widths and the seven-segment decoder for the capture
// period meter with its multiplexed decimal display.
// ----------------------------------------------------------------------------
package cpdd_pkg;

	localparam int POS_W = 2;   // digit_position field
	localparam int SEG_W = 7;   // segments field, bit0 = a .. bit6 = g
	localparam int VAL_W = 32;  // capture_value and period fields

	typedef enum logic {
		OP_CAPTURE = 1'b0,
		OP_SCAN    = 1'b1
	} opcode_t;

	// 10 ** n, evaluated at elaboration
	function automatic longint unsigned pow10(int n);
		longint unsigned acc;
		acc = 64'd1;
		for (int i = 0; i < n; i++) begin
			acc = acc * 64'd10;
		end
		return acc;
	endfunction

	// decimal digit to lit segments; non-decimal codes stay dark
	function automatic logic [SEG_W-1:0] seg_of(logic [3:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0:    s = 7'h3F;
			4'd1:    s = 7'h06;
			4'd2:    s = 7'h5B;
			4'd3:    s = 7'h4F;
			4'd4:    s = 7'h66;
			4'd5:    s = 7'h6D;
			4'd6:    s = 7'h7D;
			4'd7:    s = 7'h07;
			4'd8:    s = 7'h7F;
			4'd9:    s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/core/capture_period_decimal_display.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_period_decimal_display
// Input-capture period meter driving a multiplexed decimal seven-segment
// display, one digit per scan tick.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes through six register stages, s1 to s5 and
//   the output registers, before its result can be taken.
// Throughput: one item per cycle; the six-stage digit pipeline holds up to
//   six items in flight, and the input stalls only when all six are full and
//   the result is stalled.
// Reset (arst_n low): last capture, period and scan position clear to zero
//   (thousands digit first); all pipeline stages are emptied.
// ----------------------------------------------------------------------------
module capture_period_decimal_display #(
	parameter int COUNTER_WIDTH = 32,
	parameter int DIGIT_COUNT   = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// item channel
	input  logic                           item_valid,
	output logic                           item_stall,
	input  cpdd_pkg::opcode_t              opcode,
	input  logic [cpdd_pkg::VAL_W-1:0]     capture_value,
	// result channel
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [cpdd_pkg::POS_W-1:0]     digit_position,
	output logic [cpdd_pkg::SEG_W-1:0]     segments,
	output logic [cpdd_pkg::VAL_W-1:0]     period
);
	import cpdd_pkg::*;

	// ---------------------------------------------------------------------
	// Derived sizes
	// ---------------------------------------------------------------------
	localparam int CW = COUNTER_WIDTH;
	// Shown value is period mod Modulus
	localparam longint unsigned Modulus = pow10(DIGIT_COUNT);
	localparam int RW  = $clog2(Modulus);                // remainder width
	localparam int PW  = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam int KW  = $clog2(DIGIT_COUNT + 1);        // decade index 0..DIGIT_COUNT
	localparam int NCH = (CW + 7) / 8;                   // byte chunks of the period
	localparam int SW  = RW + 10;                        // chunk sum < 1024 * Modulus
	localparam int HW  = RW + 5;                         // after first reduction half
	localparam int MW  = RW + 2;                         // reciprocal width
	localparam int PRW = RW + MW;                        // reciprocal product width
	localparam int SHW = $clog2(2 * RW + 1);             // reciprocal shift width

	localparam logic [SW-1:0] ModSum  = SW'(Modulus);
	localparam logic [HW-1:0] ModPart = HW'(Modulus);
	localparam logic [PW-1:0] LastPos = PW'(DIGIT_COUNT - 1);

	// ---------------------------------------------------------------------
	// Constant tables.
	// magic_tab[k] / shift_tab[k] give an exact floor(r / 10**k) for any
	// r < 2**RW as (r * magic) >> shift (round-up reciprocal).
	// ChunkMod in g_chunk[i] = 2**(8*i) mod Modulus folds each period byte.
	// ---------------------------------------------------------------------
	logic [MW-1:0]  magic_tab [DIGIT_COUNT+1];
	logic [SHW-1:0] shift_tab [DIGIT_COUNT+1];
	logic [RW+7:0]  chunk_prod [NCH];

	for (genvar k = 0; k <= DIGIT_COUNT; k++) begin : g_recip
		localparam longint unsigned Div   = pow10(k);
		localparam int              L     = $clog2(Div);
		localparam longint unsigned Magic = ((64'd1 << (RW + L)) / Div) + 64'd1;
		assign magic_tab[k] = MW'(Magic);
		assign shift_tab[k] = SHW'(RW + L);
	end

	// ---------------------------------------------------------------------
	// Handshake: each stage moves when it is empty or its successor moves.
	// ---------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5, en6;
	logic accept;

	assign en6        = !result_valid || !result_stall;
	assign en5        = !v_s5 || en6;
	assign en4        = !v_s4 || en5;
	assign en3        = !v_s3 || en4;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign item_stall = !en1;
	assign accept     = item_valid && en1;

	// ---------------------------------------------------------------------
	// Architectural state: updated at accept, so every later item sees it.
	// ---------------------------------------------------------------------
	logic [CW-1:0] last_capture_q;
	logic [CW-1:0] period_value_q;
	logic [PW-1:0] scan_pos_q;
	logic [CW-1:0] cap_now;
	logic [CW-1:0] diff;
	logic [CW-1:0] period_next;
	logic [PW-1:0] scan_next;

	assign cap_now     = capture_value[CW-1:0];
	assign diff        = cap_now - last_capture_q;   // wraps mod 2**CW
	assign period_next = (opcode == OP_CAPTURE) ? diff : period_value_q;
	assign scan_next   = (scan_pos_q == LastPos) ? '0 : scan_pos_q + PW'(1);

	// ---------------------------------------------------------------------
	// Pipeline payload
	// ---------------------------------------------------------------------
	logic [CW-1:0]  period_s1, period_s2, period_s3, period_s4, period_s5;
	logic [PW-1:0]  pos_s1, pos_s2, pos_s3, pos_s4, pos_s5;
	logic [SW-1:0]  sum_s2;
	logic [HW-1:0]  part_s3;
	logic [RW-1:0]  rem_s4;
	logic [PRW-1:0] prod_a_s5, prod_b_s5;
	logic [SHW-1:0] sh_a_s5, sh_b_s5;

	// s1 -> s2: fold the period bytes into a sum congruent mod Modulus
	logic [NCH*8-1:0] period_pad;
	logic [SW-1:0]    chunk_sum;

	assign period_pad = (NCH*8)'(period_s1);

	for (genvar i = 0; i < NCH; i++) begin : g_chunk
		localparam longint unsigned ChunkMod = (64'd1 << (8 * i)) % Modulus;
		assign chunk_prod[i] = (RW+8)'(period_pad[8*i +: 8]) * (RW+8)'(ChunkMod);
	end

	always_comb begin
		chunk_sum = '0;
		for (int i = 0; i < NCH; i++) begin
			chunk_sum = chunk_sum + SW'(chunk_prod[i]);
		end
	end

	// s2 -> s3, s3 -> s4: restoring reduction, five conditional subtracts each
	logic [SW-1:0] red_hi;
	logic [HW-1:0] red_lo;

	always_comb begin
		red_hi = sum_s2;
		for (int j = 9; j >= 5; j--) begin
			if (red_hi >= (ModSum << j)) begin
				red_hi = red_hi - (ModSum << j);
			end
		end
	end

	always_comb begin
		red_lo = part_s3;
		for (int j = 4; j >= 0; j--) begin
			if (red_lo >= (ModPart << j)) begin
				red_lo = red_lo - (ModPart << j);
			end
		end
	end

	// s4 -> s5: quotients by 10**k and 10**(k+1), k counted from the ones digit
	logic [KW-1:0] k_a, k_b;

	assign k_a = KW'(DIGIT_COUNT - 1) - KW'(pos_s4);
	assign k_b = k_a + KW'(1);

	// s5 -> out: digit = q_k - 10 * q_(k+1), exact in four bits
	logic [3:0] qa4, qb4, digit;

	assign qa4   = 4'(prod_a_s5 >> sh_a_s5);
	assign qb4   = 4'(prod_b_s5 >> sh_b_s5);
	assign digit = qa4 - 4'(qb4 * 4'd10);

	// ---------------------------------------------------------------------
	// Control registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_capture_q <= '0;
			period_value_q <= '0;
			scan_pos_q     <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			v_s5           <= 1'b0;
			result_valid   <= 1'b0;
		end else begin
			if (accept) begin
				if (opcode == OP_CAPTURE) begin
					last_capture_q <= cap_now;
					period_value_q <= diff;
				end else begin
					scan_pos_q <= scan_next;
				end
			end
			if (en1) v_s1 <= accept;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) result_valid <= v_s5;
		end
	end

	// ---------------------------------------------------------------------
	// Payload registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en1 && accept) begin
			period_s1 <= period_next;
			pos_s1    <= scan_pos_q;
		end
		if (en2 && v_s1) begin
			period_s2 <= period_s1;
			pos_s2    <= pos_s1;
			sum_s2    <= chunk_sum;
		end
		if (en3 && v_s2) begin
			period_s3 <= period_s2;
			pos_s3    <= pos_s2;
			part_s3   <= HW'(red_hi);
		end
		if (en4 && v_s3) begin
			period_s4 <= period_s3;
			pos_s4    <= pos_s3;
			rem_s4    <= RW'(red_lo);
		end
		if (en5 && v_s4) begin
			period_s5 <= period_s4;
			pos_s5    <= pos_s4;
			prod_a_s5 <= PRW'(rem_s4) * PRW'(magic_tab[k_a]);
			prod_b_s5 <= PRW'(rem_s4) * PRW'(magic_tab[k_b]);
			sh_a_s5   <= shift_tab[k_a];
			sh_b_s5   <= shift_tab[k_b];
		end
		if (en6 && v_s5) begin
			digit_position <= POS_W'(pos_s5);
			segments       <= seg_of(digit);
			period         <= VAL_W'(period_s5);
		end
	end

endmodule
